[sv/aes_pkg.sv]
// Package: payload types, controller types, S-box tables and round functions of the AES core.
`default_nettype none
package aes_pkg;

	localparam int BlockW    = 128;
	localparam int HalfW     = 64;
	localparam int WordW     = 32;
	localparam int RkRows    = 15;
	localparam int RkAddrW   = 4;
	localparam int WordIdxW  = 6;
	localparam int CfgIndexW = 3;

	localparam logic [CfgIndexW-1:0] REG_KEY_SIZE  = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_KEY_WORD0 = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_KEY_WORD1 = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_KEY_WORD2 = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_KEY_WORD3 = 3'd4;

	localparam logic [1:0] KS_128 = 2'd0;
	localparam logic [1:0] KS_192 = 2'd1;
	localparam logic [1:0] KS_256 = 2'd2;
	localparam logic [1:0] KS_ALT = 2'd3;

	localparam logic [7:0] GF_POLY = 8'h1b;

	typedef struct packed {
		logic             mode;
		logic [HalfW-1:0] block_high;
		logic [HalfW-1:0] block_low;
	} in_item_t;

	typedef struct packed {
		logic [HalfW-1:0] result_high;
		logic [HalfW-1:0] result_low;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_KEY0,
		ST_ROUND,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic                load;
		logic                key0;
		logic                round;
		logic                last;
		logic                dec;
		logic                exp_start;
		logic                exp_step;
		logic [WordIdxW-1:0] exp_idx;
		logic [RkAddrW-1:0]  rk_addr;
		logic                out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0] nr;
	} dp_stat_t;

	localparam logic [0:255][7:0] SBOX = {
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [0:255][7:0] INV_SBOX = {
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	// coefficient select: forward {2,3,1,1}, inverse {e,b,d,9}
	function automatic logic [7:0] mulc(input logic [7:0] a, input int sel, input logic inv);
		logic [7:0] x2, x4, x8, res;
		x2 = xt(a);
		x4 = xt(x2);
		x8 = xt(x4);
		res = a;
		if (!inv) begin
			case (sel)
				0: res = x2;
				1: res = x2 ^ a;
				default: res = a;
			endcase
		end else begin
			case (sel)
				0: res = x8 ^ x4 ^ x2;
				1: res = x8 ^ x2 ^ a;
				2: res = x8 ^ x4 ^ a;
				default: res = x8 ^ a;
			endcase
		end
		return res;
	endfunction

	function automatic logic [7:0] get_byte(input logic [BlockW-1:0] s, input int k);
		return s[BlockW-1-8*k -: 8];
	endfunction

	function automatic logic [WordW-1:0] sub_word(input logic [WordW-1:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [BlockW-1:0] sub_shift(input logic [BlockW-1:0] s, input logic inv);
		logic [BlockW-1:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inv)
					t[BlockW-1-8*(c*4+r) -: 8] = INV_SBOX[get_byte(s, ((c+4-r)%4)*4+r)];
				else
					t[BlockW-1-8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c+r)%4)*4+r)];
			end
		end
		return t;
	endfunction

	function automatic logic [BlockW-1:0] mix(input logic [BlockW-1:0] s, input logic inv);
		logic [BlockW-1:0] t;
		logic [7:0] acc;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int k = 0; k < 4; k++)
					acc = acc ^ mulc(get_byte(s, c*4+k), (k+4-r)%4, inv);
				t[BlockW-1-8*(c*4+r) -: 8] = acc;
			end
		end
		return t;
	endfunction

endpackage
`default_nettype wire

[sv/aes_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module aes_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[sv/aes_datapath.sv]
// Datapath: key registers, key expansion, round-key RAM, shared round unit and output register.
`default_nettype none
module aes_datapath import aes_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [HalfW-1:0]     cfg_wdata,
	input  wire in_item_t             in_data,
	input  wire dp_cmd_t              cmd,
	output dp_stat_t                  stat,
	output out_item_t                 out_data
);
	logic [1:0]        key_size_q;
	logic [HalfW-1:0]  key_q [4];
	logic [WordW-1:0]  win_q [8];
	logic [2:0]        j_q;
	logic [7:0]        rc_q;
	logic [95:0]       row_q;
	logic [BlockW-1:0] state_q;
	logic [BlockW-1:0] rk_data;
	logic [BlockW-1:0] rnd_out;
	logic [BlockW-1:0] after_sub;
	logic [WordW-1:0]  new_w;
	logic [WordW-1:0]  t;
	logic [HalfW-1:0]  kw;
	logic [2:0]        nk_m1;
	logic [3:0]        nr;
	logic              from_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= KS_128;
			for (int i = 0; i < 4; i++)
				key_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_SIZE:  key_size_q <= (cfg_wdata[1:0] == KS_ALT) ? KS_256 : cfg_wdata[1:0];
				REG_KEY_WORD0: key_q[0] <= cfg_wdata;
				REG_KEY_WORD1: key_q[1] <= cfg_wdata;
				REG_KEY_WORD2: key_q[2] <= cfg_wdata;
				REG_KEY_WORD3: key_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (key_size_q)
			KS_128: begin nk_m1 = 3'd3; nr = 4'd10; end
			KS_192: begin nk_m1 = 3'd5; nr = 4'd12; end
			default: begin nk_m1 = 3'd7; nr = 4'd14; end
		endcase
	end
	assign stat.nr = nr;

	// next schedule word
	always_comb begin
		from_key = (cmd.exp_idx <= {3'd0, nk_m1});
		kw = key_q[cmd.exp_idx[2:1]];
		t = win_q[0];
		if (j_q == 3'd0)
			t = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rc_q, 24'd0};
		else if (nk_m1 == 3'd7 && j_q == 3'd4)
			t = sub_word(win_q[0]);
		if (from_key)
			new_w = cmd.exp_idx[0] ? kw[31:0] : kw[63:32];
		else
			new_w = win_q[nk_m1] ^ t;
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_start) begin
			j_q  <= 3'd0;
			rc_q <= 8'h01;
		end else if (cmd.exp_step) begin
			j_q <= (j_q == nk_m1) ? 3'd0 : j_q + 3'd1;
			if (!from_key && j_q == 3'd0)
				rc_q <= xt(rc_q);
			win_q[0] <= new_w;
			for (int i = 1; i < 8; i++)
				win_q[i] <= win_q[i-1];
			row_q <= {row_q[63:0], new_w};
		end
	end

	aes_ram #(.Width(BlockW), .Depth(RkRows)) u_rk_ram (
		.clk   (clk),
		.we    (cmd.exp_step && cmd.exp_idx[1:0] == 2'd3),
		.waddr (cmd.exp_idx[5:2]),
		.wdata ({row_q, new_w}),
		.raddr (cmd.rk_addr),
		.rdata (rk_data)
	);

	always_comb begin
		after_sub = sub_shift(state_q, cmd.dec);
		if (!cmd.dec)
			rnd_out = (cmd.last ? after_sub : mix(after_sub, 1'b0)) ^ rk_data;
		else
			rnd_out = cmd.last ? (after_sub ^ rk_data) : mix(after_sub ^ rk_data, 1'b1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			state_q <= {in_data.block_high, in_data.block_low};
		else if (cmd.key0)
			state_q <= state_q ^ rk_data;
		else if (cmd.round)
			state_q <= rnd_out;
		if (cmd.out_load)
			out_data <= state_q;
	end
endmodule
`default_nettype wire

[sv/aes_control.sv]
// Controller: sequences key expansion, rounds and the output handshake.
`default_nettype none
module aes_control import aes_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic                 in_valid,
	input  wire logic                 in_mode,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire dp_stat_t             stat,
	output dp_cmd_t                   cmd
);
	ctl_state_t          state_q, state_d;
	logic                sched_q;
	logic                dec_q, dec_d;
	logic [3:0]          rnd_q, rnd_d;
	logic [WordIdxW-1:0] idx_q, idx_d;
	logic                cfg_hit;
	logic                exp_done;

	assign cfg_hit  = cfg_we && (cfg_index <= REG_KEY_WORD3);
	assign exp_done = (idx_q == {stat.nr, 2'b11});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sched_q   <= 1'b0;
			dec_q     <= 1'b0;
			rnd_q     <= '0;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			dec_q   <= dec_d;
			rnd_q   <= rnd_d;
			idx_q   <= idx_d;
			if (cfg_hit)
				sched_q <= 1'b0;
			else if (state_q == ST_EXPAND && exp_done)
				sched_q <= 1'b1;
			if (cmd.out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		dec_d    = dec_q;
		rnd_d    = rnd_q;
		idx_d    = idx_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.dec  = dec_q;
		cmd.exp_idx = idx_q;
		cmd.last = (rnd_q == stat.nr);
		case (state_q)
			ST_IDLE: begin
				if (!sched_q) begin
					if (in_valid && !cfg_hit) begin
						cmd.exp_start = 1'b1;
						idx_d   = '0;
						state_d = ST_EXPAND;
					end
				end else begin
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.load    = 1'b1;
						dec_d       = in_mode;
						cmd.rk_addr = in_mode ? stat.nr : '0;
						state_d     = ST_KEY0;
					end
				end
			end
			ST_EXPAND: begin
				// a key or key-size register write mid-expansion restarts it from idle
				if (cfg_hit) begin
					state_d = ST_IDLE;
				end else begin
					cmd.exp_step = 1'b1;
					idx_d = idx_q + WordIdxW'(1);
					if (exp_done)
						state_d = ST_IDLE;
				end
			end
			ST_KEY0: begin
				cmd.key0    = 1'b1;
				cmd.rk_addr = dec_q ? stat.nr - 4'd1 : 4'd1;
				rnd_d       = 4'd1;
				state_d     = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round   = 1'b1;
				cmd.rk_addr = dec_q ? stat.nr - rnd_q - 4'd1 : rnd_q + 4'd1;
				rnd_d       = rnd_q + 4'd1;
				if (cmd.last)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[sv/aes_block_cipher.sv]
// Top level of the AES-128/192/256 encrypt and decrypt core.
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data   (mode, block_high, block_low)
// out      output     out_valid / out_ready  out_data  (result_high, result_low)
// cfg      input      cfg_we                 cfg_index, cfg_wdata
//
// An item passes from acceptance through the key-0 step and Nr rounds to the output register,
// done by the single shared round unit that does one round per cycle; the next item
// can be accepted only after the previous one has been loaded into the output register.
// After reset or a key register write, the first item waits for the key expansion:
// a start step, then 4 * (Nr + 1) schedule words, one schedule word per cycle.
// A finished item waits in the output register while out_ready is low.
`default_nettype none
module aes_block_cipher import aes_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_data,
	input  wire logic                 cfg_we,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [HalfW-1:0]     cfg_wdata
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	aes_control u_control (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.in_valid  (in_valid),
		.in_mode   (in_data.mode),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	aes_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);
endmodule
`default_nettype wire

[tb/aes_block_cipher_tb.sv]
// Testbench for the AES block cipher: an independent cipher calculation predicts every item.
`default_nettype none
module aes_block_cipher_tb;
	import aes_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_item_t in_data;
	out_item_t out_data;
	logic cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [HalfW-1:0] cfg_wdata;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	aes_block_cipher dut (.*);

	// own copy of the key registers and the expanded schedule
	logic [1:0] key_len;
	logic [63:0] key_reg [4];
	logic [31:0] sched [60];
	logic [7:0] fbox [256];
	logic [7:0] ibox [256];

	in_item_t pending_q [$];
	out_item_t cipher_q [$];
	int send_idle, recv_idle;
	int errors;
	int stall;

	function automatic logic [7:0] gx(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gm(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= a;
			a = gx(a);
		end
		return acc;
	endfunction

	// derive both boxes from the field inverse and the affine map
	task automatic build_boxes();
		logic [7:0] inv, p, x;
		for (int i = 0; i < 256; i++) begin
			inv = 8'h01;
			p = i[7:0];
			for (int k = 0; k < 8; k++) begin
				if ((254 >> k) & 1) inv = gm(inv, p);
				p = gm(p, p);
			end
			if (i == 0) inv = 8'h00;
			x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			fbox[i] = x;
			ibox[x] = i[7:0];
		end
	endtask

	function automatic int nk_words();
		return key_len == KS_128 ? 4 : (key_len == KS_192 ? 6 : 8);
	endfunction

	function automatic logic [31:0] box_word(input logic [31:0] w);
		return {fbox[w[31:24]], fbox[w[23:16]], fbox[w[15:8]], fbox[w[7:0]]};
	endfunction

	task automatic expand_keys();
		int nk, nr;
		logic [7:0] rc;
		logic [31:0] t;
		nk = nk_words();
		nr = nk + 6;
		rc = 8'h01;
		for (int i = 0; i < nk; i++)
			sched[i] = (i & 1) ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
		for (int i = nk; i < 4 * (nr + 1); i++) begin
			t = sched[i - 1];
			if (i % nk == 0) begin
				t = box_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gx(rc);
			end else if (nk == 8 && i % nk == 4) begin
				t = box_word(t);
			end
			sched[i] = sched[i - nk] ^ t;
		end
	endtask

	function automatic out_item_t cipher_block(input in_item_t it);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] col [4];
		logic [7:0] fm [4];
		logic [7:0] im [4];
		int nr, rnd;
		out_item_t o;
		fm = '{8'h02, 8'h03, 8'h01, 8'h01};
		im = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		nr = nk_words() + 6;
		for (int i = 0; i < 8; i++) begin
			s[i] = it.block_high[63 - 8 * i -: 8];
			s[i + 8] = it.block_low[63 - 8 * i -: 8];
		end
		for (int step = 0; step <= nr; step++) begin
			rnd = (it.mode == MODE_DEC) ? nr - step : step;
			if (step > 0) begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						if (it.mode == MODE_DEC) t[((c + r) & 3) * 4 + r] = ibox[s[c * 4 + r]];
						else t[c * 4 + r] = fbox[s[((c + r) & 3) * 4 + r]];
				s = t;
				// encryption mixes before the key, decryption after
				if (it.mode == MODE_ENC && step < nr) begin
					for (int c = 0; c < 4; c++) begin
						for (int k = 0; k < 4; k++) col[k] = s[c * 4 + k];
						for (int r = 0; r < 4; r++) begin
							s[c * 4 + r] = 8'h00;
							for (int k = 0; k < 4; k++)
								s[c * 4 + r] ^= gm(col[k], fm[(k - r) & 3]);
						end
					end
				end
			end
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					s[c * 4 + r] ^= sched[rnd * 4 + c][31 - 8 * r -: 8];
			if (it.mode == MODE_DEC && step > 0 && step < nr) begin
				for (int c = 0; c < 4; c++) begin
					for (int k = 0; k < 4; k++) col[k] = s[c * 4 + k];
					for (int r = 0; r < 4; r++) begin
						s[c * 4 + r] = 8'h00;
						for (int k = 0; k < 4; k++)
							s[c * 4 + r] ^= gm(col[k], im[(k - r) & 3]);
					end
				end
			end
		end
		for (int i = 0; i < 8; i++) begin
			o.result_high[63 - 8 * i -: 8] = s[i];
			o.result_low[63 - 8 * i -: 8] = s[i + 8];
		end
		return o;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
			if (!in_valid || in_ready) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					in_data <= pending_q.pop_front();
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// monitor: predict on input acceptance, compare on output acceptance
	always @(posedge clk) begin
		out_item_t got, exp_item;
		if (arst_n) begin
			if (in_valid && in_ready) cipher_q.push_back(cipher_block(in_data));
			if (out_valid && out_ready) begin
				got = out_data;
				if (cipher_q.size() == 0) begin
					$display("%t: unexpected result %h", $realtime, got);
					errors++;
				end else begin
					exp_item = cipher_q.pop_front();
					if (got.result_high !== exp_item.result_high) begin
						$display("%t: result_high expected %h actual %h", $realtime,
							exp_item.result_high, got.result_high);
						errors++;
					end
					if (got.result_low !== exp_item.result_low) begin
						$display("%t: result_low expected %h actual %h", $realtime,
							exp_item.result_low, got.result_low);
						errors++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) stall = 0;
			else stall++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (stall > 20000) begin
			$display("aes_block_cipher test failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_KEY_SIZE: key_len = (val[1:0] == KS_ALT) ? KS_256 : val[1:0];
			REG_KEY_WORD0: key_reg[0] = val;
			REG_KEY_WORD1: key_reg[1] = val;
			REG_KEY_WORD2: key_reg[2] = val;
			REG_KEY_WORD3: key_reg[3] = val;
			default: ;
		endcase
		if (idx <= REG_KEY_WORD3) expand_keys();
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || in_valid || cipher_q.size() > 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		it.mode = 1'($urandom_range(1));
		it.block_high = rand64();
		it.block_low = rand64();
		return it;
	endfunction

	task automatic push(input logic m, input logic [63:0] h, input logic [63:0] l);
		in_item_t it;
		it.mode = m;
		it.block_high = h;
		it.block_low = l;
		pending_q.push_back(it);
	endtask

	initial begin
		logic [1:0] ks;
		errors = 0;
		stall = 0;
		send_idle = 30;
		recv_idle = 81;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		key_len = KS_128;
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
		build_boxes();
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// directed: all-zero key straight after reset, then the standard vectors
		expand_keys();
		push(MODE_ENC, '0, '0);
		push(MODE_DEC, '0, '0);
		push(MODE_ENC, '1, '1);
		push(MODE_DEC, '1, '1);
		drain();
		write_reg(REG_KEY_WORD0, 64'h0001020304050607);
		write_reg(REG_KEY_WORD1, 64'h08090a0b0c0d0e0f);
		write_reg(REG_KEY_WORD2, 64'h1011121314151617);
		write_reg(REG_KEY_WORD3, 64'h18191a1b1c1d1e1f);
		for (int k = 0; k < 4; k++) begin
			// unused size code behaves as the longest key
			write_reg(REG_KEY_SIZE, 64'(k[1:0]));
			push(MODE_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
			push(MODE_DEC, 64'h0011223344556677, 64'h8899aabbccddeeff);
			push(MODE_ENC, 64'h8000000000000000, 64'h0000000000000001);
			drain();
		end
		// out-of-range index is ignored; rewriting the same value rebuilds the schedule
		write_reg(3'd5, '1);
		write_reg(3'd7, '1);
		write_reg(REG_KEY_WORD1, 64'h08090a0b0c0d0e0f);
		push(MODE_DEC, '1, '0);
		push(MODE_ENC, '0, '1);
		drain();

		// random phases over key sizes and keys
		for (int ph = 0; ph < 16; ph++) begin
			if (ph == 5) begin
				send_idle = 81;
				recv_idle = 30;
			end else if (ph == 11) begin
				send_idle = 0;
				recv_idle = 0;
			end
			ks = 2'((ph < 12) ? ph % 3 : $urandom_range(3));
			write_reg(REG_KEY_SIZE, 64'(ks));
			for (int w = 0; w < 4; w++) begin
				case ($urandom_range(5))
					0: write_reg(REG_KEY_WORD0 + CfgIndexW'(w), '0);
					1: write_reg(REG_KEY_WORD0 + CfgIndexW'(w), '1);
					default: write_reg(REG_KEY_WORD0 + CfgIndexW'(w), rand64());
				endcase
			end
			for (int n = 0; n < 100; n++) pending_q.push_back(rand_item());
			drain();
		end
		if (errors == 0) $display("aes_block_cipher test passed");
		else $display("aes_block_cipher test failed");
		$finish;
	end

endmodule
`default_nettype wire
